>>> hdl/i2c_master_bit_engine_top_defines.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and quiet in reset
`define I2CBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet in reset
`define I2CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, phase and status codes, and the engine state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbe_pkg;

  // SCL pulses issued by bus recovery
  localparam int unsigned RECOVERY_PULSES = 9;

  // Ticks per phase after reset
  localparam logic [7:0] PHASE_TICKS_RST = 8'd3;

  // Configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef enum logic [3:0] {
    MODE_RECOVER = 4'd0,
    MODE_CHECK   = 4'd1,
    MODE_START   = 4'd2,
    MODE_STOP    = 4'd3,
    MODE_ACK     = 4'd4,
    MODE_NACK    = 4'd5,
    MODE_WAITACK = 4'd6,
    MODE_SEND    = 4'd7,
    MODE_RECEIVE = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    PH_0 = 3'd0,
    PH_1 = 3'd1,
    PH_2 = 3'd2,
    PH_3 = 3'd3,
    PH_4 = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2,
    ST_NACK  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t      mode;
    logic       active;
    phase_t     phase;
    logic [7:0] ticks;
    logic [3:0] bits;
    logic [7:0] shreg;
    logic       scl;
    logic       sda;
    logic [7:0] last_rx;
  } eng_state_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } eng_res_t;

endpackage

>>> hdl/i2cbe_step.sv
// ----------------------------------------------------------------------------
// I2C master bit engine tick logic
// Next engine state and completion result for one tick, purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbe_step (
  input  i2cbe_pkg::eng_state_t cur,
  input  logic [7:0]            phase_ticks,
  input  logic                  cmd_valid,
  input  logic [3:0]            mode,
  input  logic [7:0]            tx_byte,
  input  logic                  sda_in,
  output i2cbe_pkg::eng_state_t nxt,
  output i2cbe_pkg::eng_res_t   res
);

  logic       do_act;
  logic [7:0] hold_ticks;
  logic [4:0] pulse_cnt;
  logic [3:0] bits_inc;
  logic [7:0] rx_shift;

  // Reload value for the phase counter; zero counts as one tick
  assign hold_ticks = (phase_ticks == 8'd0) ? 8'd0 : phase_ticks - 8'd1;
  // Recovery pulses issued so far, counting the one now ending
  assign pulse_cnt  = {1'b0, cur.bits} + 5'd1;

  always_comb begin
    nxt      = cur;
    res      = '0;
    do_act   = 1'b0;
    bits_inc = 4'd0;
    rx_shift = 8'd0;

    // Count down a held phase, or take a new command while idle
    if (cur.active) begin
      if (cur.ticks != 8'd0) begin
        nxt.ticks = cur.ticks - 8'd1;
      end else begin
        do_act = 1'b1;
      end
    end else if (cmd_valid &&
                 (mode inside {[i2cbe_pkg::MODE_RECOVER : i2cbe_pkg::MODE_RECEIVE]})) begin
      nxt.mode   = i2cbe_pkg::mode_t'(mode);
      nxt.active = 1'b1;
      nxt.phase  = i2cbe_pkg::PH_0;
      nxt.ticks  = 8'd0;
      nxt.bits   = 4'd0;
      case (i2cbe_pkg::mode_t'(mode))
        i2cbe_pkg::MODE_RECOVER: nxt.sda = 1'b1;
        i2cbe_pkg::MODE_SEND:    nxt.shreg = tx_byte;
        i2cbe_pkg::MODE_RECEIVE: begin
          nxt.sda   = 1'b1;
          nxt.shreg = 8'd0;
        end
        default: ;
      endcase
      do_act = 1'b1;
    end

    bits_inc = nxt.bits + 4'd1;
    rx_shift = {nxt.shreg[6:0], sda_in};

    // Run the action of the current phase
    if (do_act) begin
      case (nxt.mode)
        i2cbe_pkg::MODE_RECOVER: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.scl   = 1'b0;
              nxt.ticks = hold_ticks;
              if (pulse_cnt >= 5'(i2cbe_pkg::RECOVERY_PULSES)) begin
                nxt.phase = i2cbe_pkg::PH_2;
              end else begin
                nxt.bits  = bits_inc;
                nxt.phase = i2cbe_pkg::PH_0;
              end
            end
            default: begin
              nxt.scl    = 1'b1;
              nxt.sda    = 1'b1;
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        i2cbe_pkg::MODE_CHECK: begin
          nxt.active = 1'b0;
          res.done   = 1'b1;
          res.status = sda_in ? i2cbe_pkg::ST_OK : i2cbe_pkg::ST_BUSY;
        end
        i2cbe_pkg::MODE_START: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.sda   = 1'b1;
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              if (!sda_in) begin
                nxt.active = 1'b0;
                res.done   = 1'b1;
                res.status = i2cbe_pkg::ST_BUSY;
              end else begin
                nxt.sda   = 1'b0;
                nxt.phase = i2cbe_pkg::PH_2;
                nxt.ticks = hold_ticks;
              end
            end
            i2cbe_pkg::PH_2: begin
              if (sda_in) begin
                nxt.active = 1'b0;
                res.done   = 1'b1;
                res.status = i2cbe_pkg::ST_ERROR;
              end else begin
                nxt.sda   = 1'b0;
                nxt.phase = i2cbe_pkg::PH_3;
                nxt.ticks = hold_ticks;
              end
            end
            default: begin
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        i2cbe_pkg::MODE_STOP: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.sda   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_2;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_2: begin
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_3;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_3: begin
              nxt.sda   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_4;
              nxt.ticks = hold_ticks;
            end
            default: begin
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        i2cbe_pkg::MODE_ACK, i2cbe_pkg::MODE_NACK: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.sda   = (nxt.mode == i2cbe_pkg::MODE_NACK);
              nxt.phase = i2cbe_pkg::PH_2;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_2: begin
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_3;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_3: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_4;
              nxt.ticks = hold_ticks;
            end
            default: begin
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        i2cbe_pkg::MODE_WAITACK: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.sda   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_2;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_2: begin
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_3;
              nxt.ticks = hold_ticks;
            end
            default: begin
              nxt.scl    = 1'b0;
              nxt.active = 1'b0;
              res.done   = 1'b1;
              res.status = sda_in ? i2cbe_pkg::ST_NACK : i2cbe_pkg::ST_OK;
            end
          endcase
        end
        i2cbe_pkg::MODE_SEND: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.sda   = nxt.shreg[7];
              nxt.shreg = {nxt.shreg[6:0], 1'b0};
              nxt.phase = i2cbe_pkg::PH_2;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_2: begin
              nxt.scl   = 1'b1;
              nxt.bits  = bits_inc;
              nxt.phase = (bits_inc >= 4'd8) ? i2cbe_pkg::PH_3 : i2cbe_pkg::PH_0;
              nxt.ticks = hold_ticks;
            end
            default: begin
              nxt.scl    = 1'b0;
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        i2cbe_pkg::MODE_RECEIVE: begin
          case (nxt.phase)
            i2cbe_pkg::PH_0: begin
              nxt.scl   = 1'b0;
              nxt.phase = i2cbe_pkg::PH_1;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_1: begin
              nxt.scl   = 1'b1;
              nxt.phase = i2cbe_pkg::PH_2;
              nxt.ticks = hold_ticks;
            end
            i2cbe_pkg::PH_2: begin
              nxt.shreg = rx_shift;
              nxt.bits  = bits_inc;
              nxt.scl   = 1'b0;
              if (bits_inc >= 4'd8) begin
                nxt.last_rx = rx_shift;
                nxt.active  = 1'b0;
                res.done    = 1'b1;
              end else begin
                nxt.phase = i2cbe_pkg::PH_1;
                nxt.ticks = hold_ticks;
              end
            end
            default: begin
              nxt.active = 1'b0;
              res.done   = 1'b1;
            end
          endcase
        end
        default: begin
          nxt.active = 1'b0;
          res.done   = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hdl/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Each item's result is in the output register in the cycle after it is
// accepted; one item per cycle unless a result waits. Each item is one engine
// tick, worked by the tick logic in a single pass from state register to
// result register. Reset (rst_n low, synchronous) idles the engine, releases
// SCL and SDA, clears the received byte and sets phase_ticks to 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd_valid,
  input  logic [3:0]  in_mode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_sda_in,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_engine_busy,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_rx_byte,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cbe_pkg::eng_state_t state_r, state_nxt;
  i2cbe_pkg::eng_res_t   res_nxt;
  logic [7:0]            phase_ticks_r;
  logic                  out_valid_r;
  logic                  out_done_r;
  logic [1:0]            out_status_r;
  logic                  in_acc;
  logic                  cfg_wr;

  // Configuration register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == i2cbe_pkg::REG_PHASE_TICKS);
  assign prdata = (paddr[2] == i2cbe_pkg::REG_PHASE_TICKS) ? {24'd0, phase_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cbe_pkg::PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      phase_ticks_r <= pwdata[7:0];
    end
  end

  // Take an item whenever the result register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  i2cbe_step u_step (
    .cur         (state_r),
    .phase_ticks (phase_ticks_r),
    .cmd_valid   (in_cmd_valid),
    .mode        (in_mode),
    .tx_byte     (in_tx_byte),
    .sda_in      (in_sda_in),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // Advance the engine state and load the result on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= '{mode: i2cbe_pkg::MODE_RECOVER, active: 1'b0,
                           phase: i2cbe_pkg::PH_0, ticks: 8'd0, bits: 4'd0,
                           shreg: 8'd0, scl: 1'b1, sda: 1'b1, last_rx: 8'd0};
      out_valid_r     <= 1'b0;
      out_done_r      <= 1'b0;
      out_status_r    <= 2'd0;
    end else if (in_acc) begin
      state_r      <= state_nxt;
      out_valid_r  <= 1'b1;
      out_done_r   <= res_nxt.done;
      out_status_r <= res_nxt.status;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields come straight from the registered state and result registers
  assign out_valid       = out_valid_r;
  assign out_scl_out     = state_r.scl;
  assign out_sda_out     = state_r.sda;
  assign out_engine_busy = state_r.active;
  assign out_done_res    = out_done_r;
  assign out_status      = out_status_r;
  assign out_rx_byte     = state_r.last_rx;

endmodule

>>> hdl/i2cbe_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine port checker
// Watches the top level's ports and flags results that break the engine rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_top_defines.svh"

module i2cbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_engine_busy,
  input logic       out_done_res,
  input logic [1:0] out_status,
  input logic [7:0] out_rx_byte
);

  // A completing item leaves the engine idle
  `I2CBE_ASSERT_NOW(a_done_idle, out_valid && out_done_res, !out_engine_busy, "done while busy")

  // Status stays clear unless a command completes
  `I2CBE_ASSERT_NOW(a_status_quiet, out_valid && !out_done_res, out_status == 2'd0, "stray status")

  // Input is held off only while a result waits
  `I2CBE_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input stalled without cause")

  // Hold a stalled result
  `I2CBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rx_byte), "result dropped")

endmodule

bind i2c_master_bit_engine_top i2cbe_checker u_i2cbe_checker (.*);

>>> dv/i2c_master_bit_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine line checker
// Watches the tick, line and configuration ports, runs its own tick-true copy
// of the engine on every accepted tick item and compares each accepted line
// item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module i2c_master_bit_engine_checker
  import i2cbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd_valid,
  input  logic [3:0]  in_mode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_sda_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_scl_out,
  input  logic        out_sda_out,
  input  logic        out_engine_busy,
  input  logic        out_done_res,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_rx_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_items,
  output int          mismatch_count
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    status_t    status;
    logic [7:0] rx;
  } line_item_t;

  line_item_t predicted_lines[$];

  // Engine copy and its configuration
  logic [7:0] cfg_ticks;
  mode_t      eng_mode;
  logic       eng_active;
  phase_t     eng_phase;
  logic [7:0] eng_wait;
  logic [3:0] eng_bits;
  logic [7:0] eng_shift;
  logic       eng_scl;
  logic       eng_sda;
  logic [7:0] eng_rx;
  logic       tick_done;
  status_t    tick_status;
  int         errors = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  function automatic void reset_engine();
    cfg_ticks  = PHASE_TICKS_RST;
    eng_mode   = MODE_RECOVER;
    eng_active = 1'b0;
    eng_phase  = PH_0;
    eng_wait   = 8'd0;
    eng_bits   = 4'd0;
    eng_shift  = 8'd0;
    eng_scl    = 1'b1;
    eng_sda    = 1'b1;
    eng_rx     = 8'd0;
  endfunction

  // Move to the next phase and hold the lines for one phase length
  function automatic void hold_phase(phase_t nxt);
    eng_phase = nxt;
    eng_wait  = ((cfg_ticks == 8'd0) ? 8'd1 : cfg_ticks) - 8'd1;
  endfunction

  function automatic void complete(status_t st);
    eng_active  = 1'b0;
    tick_done   = 1'b1;
    tick_status = st;
  endfunction

  // One action of the running command
  function automatic void run_action(logic sda_now);
    case (eng_mode)
      MODE_RECOVER: begin
        if (eng_phase == PH_0) begin
          eng_scl = 1'b1;
          hold_phase(PH_1);
        end else if (eng_phase == PH_1) begin
          eng_scl = 1'b0;
          if (int'(eng_bits) + 1 >= RECOVERY_PULSES) begin
            hold_phase(PH_2);
          end else begin
            eng_bits++;
            hold_phase(PH_0);
          end
        end else begin
          eng_scl = 1'b1;
          eng_sda = 1'b1;
          complete(ST_OK);
        end
      end
      MODE_CHECK: complete(sda_now ? ST_OK : ST_BUSY);
      MODE_START: begin
        case (eng_phase)
          PH_0: begin
            eng_sda = 1'b1;
            eng_scl = 1'b1;
            hold_phase(PH_1);
          end
          PH_1: begin
            if (!sda_now) begin
              complete(ST_BUSY);
            end else begin
              eng_sda = 1'b0;
              hold_phase(PH_2);
            end
          end
          PH_2: begin
            if (sda_now) begin
              complete(ST_ERROR);
            end else begin
              eng_sda = 1'b0;
              hold_phase(PH_3);
            end
          end
          default: complete(ST_OK);
        endcase
      end
      MODE_STOP: begin
        case (eng_phase)
          PH_0: begin
            eng_scl = 1'b0;
            hold_phase(PH_1);
          end
          PH_1: begin
            eng_sda = 1'b0;
            hold_phase(PH_2);
          end
          PH_2: begin
            eng_scl = 1'b1;
            hold_phase(PH_3);
          end
          PH_3: begin
            eng_sda = 1'b1;
            hold_phase(PH_4);
          end
          default: complete(ST_OK);
        endcase
      end
      MODE_ACK, MODE_NACK: begin
        case (eng_phase)
          PH_0: begin
            eng_scl = 1'b0;
            hold_phase(PH_1);
          end
          PH_1: begin
            eng_sda = (eng_mode == MODE_NACK);
            hold_phase(PH_2);
          end
          PH_2: begin
            eng_scl = 1'b1;
            hold_phase(PH_3);
          end
          PH_3: begin
            eng_scl = 1'b0;
            hold_phase(PH_4);
          end
          default: complete(ST_OK);
        endcase
      end
      MODE_WAITACK: begin
        case (eng_phase)
          PH_0: begin
            eng_scl = 1'b0;
            hold_phase(PH_1);
          end
          PH_1: begin
            eng_sda = 1'b1;
            hold_phase(PH_2);
          end
          PH_2: begin
            eng_scl = 1'b1;
            hold_phase(PH_3);
          end
          default: begin
            eng_scl = 1'b0;
            complete(sda_now ? ST_NACK : ST_OK);
          end
        endcase
      end
      MODE_SEND: begin
        case (eng_phase)
          PH_0: begin
            eng_scl = 1'b0;
            hold_phase(PH_1);
          end
          PH_1: begin
            eng_sda   = eng_shift[7];
            eng_shift = {eng_shift[6:0], 1'b0};
            hold_phase(PH_2);
          end
          PH_2: begin
            eng_scl = 1'b1;
            eng_bits++;
            if (eng_bits >= 4'd8) begin
              hold_phase(PH_3);
            end else begin
              hold_phase(PH_0);
            end
          end
          default: begin
            eng_scl = 1'b0;
            complete(ST_OK);
          end
        endcase
      end
      MODE_RECEIVE: begin
        case (eng_phase)
          PH_0: begin
            eng_scl = 1'b0;
            hold_phase(PH_1);
          end
          PH_1: begin
            eng_scl = 1'b1;
            hold_phase(PH_2);
          end
          PH_2: begin
            eng_shift = {eng_shift[6:0], sda_now};
            eng_bits++;
            eng_scl = 1'b0;
            if (eng_bits >= 4'd8) begin
              eng_rx = eng_shift;
              complete(ST_OK);
            end else begin
              hold_phase(PH_1);
            end
          end
          default: complete(ST_OK);
        endcase
      end
      default: complete(ST_OK);
    endcase
  endfunction

  // Advance the engine copy by one tick and return the line item it gives
  function automatic line_item_t advance_engine(logic cmd, logic [3:0] mode,
                                                logic [7:0] tx, logic sda_now);
    line_item_t res;
    tick_done   = 1'b0;
    tick_status = ST_OK;
    if (eng_active) begin
      if (eng_wait != 8'd0) eng_wait--;
      else run_action(sda_now);
    end else if (cmd && mode <= MODE_RECEIVE) begin
      eng_mode   = mode_t'(mode);
      eng_active = 1'b1;
      eng_phase  = PH_0;
      eng_wait   = 8'd0;
      eng_bits   = 4'd0;
      if (eng_mode == MODE_RECOVER) begin
        eng_sda = 1'b1;
      end else if (eng_mode == MODE_SEND) begin
        eng_shift = tx;
      end else if (eng_mode == MODE_RECEIVE) begin
        eng_sda   = 1'b1;
        eng_shift = 8'd0;
      end
      run_action(sda_now);
    end
    res.scl    = eng_scl;
    res.sda    = eng_sda;
    res.busy   = eng_active;
    res.done   = tick_done;
    res.status = tick_status;
    res.rx     = eng_rx;
    return res;
  endfunction

  task automatic check_line(line_item_t want);
    if (out_scl_out !== want.scl)
      report_mismatch($sformatf("scl_out: got %0h, expected %0h", out_scl_out, want.scl));
    if (out_sda_out !== want.sda)
      report_mismatch($sformatf("sda_out: got %0h, expected %0h", out_sda_out, want.sda));
    if (out_engine_busy !== want.busy)
      report_mismatch($sformatf("engine_busy: got %0h, expected %0h",
                                out_engine_busy, want.busy));
    if (out_done_res !== want.done)
      report_mismatch($sformatf("done_res: got %0h, expected %0h", out_done_res, want.done));
    if (out_status !== want.status)
      report_mismatch($sformatf("status: got %0h, expected %0h", out_status, want.status));
    if (out_rx_byte !== want.rx)
      report_mismatch($sformatf("rx_byte: got %0h, expected %0h", out_rx_byte, want.rx));
  endtask

  // Retire line items first, then predict the tick accepted on this edge
  always @(posedge clk) begin : watch_ports
    line_item_t want;
    if (!rst_n) begin
      reset_engine();
      predicted_lines.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_lines.size() == 0) begin
          report_mismatch("line item arrived with none predicted");
        end else begin
          want = predicted_lines.pop_front();
          check_line(want);
        end
      end
      if (in_valid && in_ready)
        predicted_lines.push_back(advance_engine(in_cmd_valid, in_mode, in_tx_byte,
                                                 in_sda_in));
      if (psel && penable && pwrite && pready && paddr[2] == REG_PHASE_TICKS)
        cfg_ticks = pwdata[7:0];
    end
    pending_items <= predicted_lines.size();
  end

endmodule

>>> dv/i2c_master_bit_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives engine ticks through the tick channel with random gaps and result
// stalls: a directed pass over every command and its corner cases, then
// random command streams under several phase lengths. A separate checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module i2c_master_bit_engine_top_test;
  import i2cbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int DRAIN_MAX      = 8000;
  localparam int NUM_PHASES     = 6;
  localparam logic [2:0] PHASE_TICKS_ADDR = {REG_PHASE_TICKS, 2'b00};
  localparam logic [2:0] SPARE_ADDR       = {~REG_PHASE_TICKS, 2'b00};

  // Phase length and tick count of each random phase (phase 4 draws its own)
  localparam logic [7:0] PHASE_LEN [NUM_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd9, 8'd5, 8'd1};
  localparam int PHASE_ITEMS [NUM_PHASES]       = '{120, 80, 60, 70, 70, 50};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd_valid = 1'b0;
  logic [3:0]  in_mode = 4'd0;
  logic [7:0]  in_tx_byte = 8'd0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_engine_busy;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic [7:0]  out_rx_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  int          pending_items;
  int          mismatch_count;
  logic        no_idle = 1'b0;
  logic        seen_busy = 1'b0;
  int          stalled_cycles = 0;

  i2c_master_bit_engine_top dut (.*);

  i2c_master_bit_engine_checker line_checker (.*);

  always #1 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Offer one tick item and hold it until accepted
  task automatic send_tick(logic cmd, logic [3:0] mode, logic [7:0] tx, logic sda);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_valid <= cmd;
    in_mode      <= mode;
    in_tx_byte   <= tx;
    in_sda_in    <= sda;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_items != 0);
  endtask

  // Feed idle ticks one at a time until the engine reports idle
  task automatic drain_engine();
    int n;
    in_valid <= 1'b0;
    wait_drained();
    for (n = 0; n < DRAIN_MAX && seen_busy; n++) begin
      send_tick(1'b0, 4'($urandom), 8'($urandom), 1'($urandom));
      in_valid <= 1'b0;
      wait_drained();
    end
  endtask

  // Issue one command from idle and tick it to completion; SDA reads lvl_a
  // until tick switch_at, then lvl_b; flood offers new commands every tick
  task automatic run_directed(logic [3:0] mode, logic [7:0] tx, logic lvl_a,
                              int switch_at, logic lvl_b, logic flood);
    int idx;
    idx = 0;
    do begin
      send_tick(idx == 0 || flood, (idx == 0) ? mode : 4'($urandom),
                (idx == 0) ? tx : 8'($urandom), (idx < switch_at) ? lvl_a : lvl_b);
      in_valid <= 1'b0;
      wait_drained();
      idx++;
    end while (seen_busy && idx < DRAIN_MAX);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Change the phase length with the engine idle; junk in the upper bits
  task automatic set_phase_ticks(logic [7:0] len);
    logic [31:0] data;
    repeat (2) @(posedge clk);
    data = $urandom;
    data[7:0] = len;
    write_reg(PHASE_TICKS_ADDR, data);
    if ($urandom_range(0, 1) == 0) write_reg(SPARE_ADDR, $urandom);
  endtask

  // Line receiver: draw a stall before each item, keep ready up until taken
  initial begin : line_sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen_busy = out_engine_busy;
    end
  end

  // Abort when no item moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    logic [7:0] len;
    logic [3:0] rnd_mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset phase length
    run_directed(MODE_CHECK, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_CHECK, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(4'd9, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(4'd15, 8'hFF, 1'b0, 1, 1'b0, 1'b0);
    send_tick(1'b0, MODE_START, 8'hFF, 1'b1);
    drain_engine();
    // start: bus held low, SDA never follows, clean start
    run_directed(MODE_START, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_START, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_START, 8'h00, 1'b1, int'(PHASE_TICKS_RST) + 1, 1'b0, 1'b0);
    // remaining commands at the shortest phase
    set_phase_ticks(8'd1);
    run_directed(MODE_STOP, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_ACK, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_NACK, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_WAITACK, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_WAITACK, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_SEND, 8'hFF, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_SEND, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_SEND, 8'hA5, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_RECEIVE, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    run_directed(MODE_RECEIVE, 8'h00, 1'b0, 1, 1'b0, 1'b0);
    run_directed(MODE_RECOVER, 8'h00, 1'b1, 1, 1'b1, 1'b0);
    // commands offered while busy, the completion tick included
    run_directed(MODE_SEND, 8'h5A, 1'b1, 1, 1'b1, 1'b1);
    run_directed(MODE_RECEIVE, 8'h00, 1'b1, 8, 1'b0, 1'b1);
    // clean start at the shortest phase
    run_directed(MODE_START, 8'h00, 1'b1, 2, 1'b0, 1'b0);

    // Random command streams under several phase lengths
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      len = (ph == 4) ? 8'($urandom_range(3, 8)) : PHASE_LEN[ph];
      set_phase_ticks(len);
      for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if (n % 64 == 0) no_idle <= ($urandom_range(0, 3) == 0);
        rnd_mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        send_tick($urandom_range(0, 3) != 0, rnd_mode, 8'($urandom), 1'($urandom));
      end
      drain_engine();
    end

    // Let the last line items settle, then give the verdict
    no_idle <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_items == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/i2cbe_pkg.sv
hdl/i2cbe_step.sv
hdl/i2c_master_bit_engine_top.sv
hdl/i2cbe_checker.sv
dv/i2c_master_bit_engine_checker.sv
dv/i2c_master_bit_engine_top_test.sv
